// ----- src/u2cp_pkg.sv -----
// Package for the UTF-8 to Windows-1250 decoder: payload types, constants
// and the code point to cp1250 mapping function. No dependencies.
package u2cp_pkg;

  localparam int QueueDepth = 4;

  localparam logic [7:0] ByteQuestion = 8'h3F;
  localparam logic [7:0] ByteCr = 8'h0D;
  localparam logic [7:0] ByteLf = 8'h0A;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       string_end;
    logic       run_last;
  } out_item_t;

  // Work record from front to back: up to three results per input.
  typedef struct packed {
    logic       has_char;
    logic       char_is_lf;
    logic       char_map;
    logic [7:0] char_byte;
    logic [15:0] code;
    logic       has_q;
    logic       has_term;
  } work_t;

  function automatic logic [7:0] map_code(input logic [15:0] u);
    logic [7:0] r;
    r = ByteQuestion;
    if (u >= 16'h00A0 && u <= 16'h00FF) begin
      case (u[7:0])
        8'hA0, 8'hA4, 8'hA6, 8'hA7, 8'hA8, 8'hA9, 8'hAB, 8'hAC, 8'hAD, 8'hAE,
        8'hB0, 8'hB1, 8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hBB,
        8'hC1, 8'hC2, 8'hC4, 8'hC7, 8'hC9, 8'hCB, 8'hCD, 8'hCE,
        8'hD3, 8'hD4, 8'hD6, 8'hD7, 8'hDA, 8'hDC, 8'hDD, 8'hDF,
        8'hE1, 8'hE2, 8'hE4, 8'hE7, 8'hE9, 8'hEB, 8'hED, 8'hEE,
        8'hF3, 8'hF4, 8'hF6, 8'hF7, 8'hFA, 8'hFC, 8'hFD: r = u[7:0];
        default: r = ByteQuestion;
      endcase
    end else begin
      case (u)
        16'h20AC: r = 8'h80; 16'h201A: r = 8'h82; 16'h201E: r = 8'h84;
        16'h2026: r = 8'h85; 16'h2020: r = 8'h86; 16'h2021: r = 8'h87;
        16'h2030: r = 8'h89; 16'h0160: r = 8'h8A; 16'h2039: r = 8'h8B;
        16'h015A: r = 8'h8C; 16'h0164: r = 8'h8D; 16'h017D: r = 8'h8E;
        16'h0179: r = 8'h8F; 16'h2018: r = 8'h91; 16'h2019: r = 8'h92;
        16'h201C: r = 8'h93; 16'h201D: r = 8'h94; 16'h2022: r = 8'h95;
        16'h2013: r = 8'h96; 16'h2014: r = 8'h97; 16'h2122: r = 8'h99;
        16'h0161: r = 8'h9A; 16'h203A: r = 8'h9B; 16'h015B: r = 8'h9C;
        16'h0165: r = 8'h9D; 16'h017E: r = 8'h9E; 16'h017A: r = 8'h9F;
        16'h02C7: r = 8'hA1; 16'h02D8: r = 8'hA2; 16'h0141: r = 8'hA3;
        16'h0104: r = 8'hA5; 16'h015E: r = 8'hAA; 16'h017B: r = 8'hAF;
        16'h02DB: r = 8'hB2; 16'h0142: r = 8'hB3; 16'h0105: r = 8'hB9;
        16'h015F: r = 8'hBA; 16'h013D: r = 8'hBC; 16'h02DD: r = 8'hBD;
        16'h013E: r = 8'hBE; 16'h017C: r = 8'hBF; 16'h0154: r = 8'hC0;
        16'h0102: r = 8'hC3; 16'h0139: r = 8'hC5; 16'h0106: r = 8'hC6;
        16'h010C: r = 8'hC8; 16'h0118: r = 8'hCA; 16'h011A: r = 8'hCC;
        16'h010E: r = 8'hCF; 16'h0110: r = 8'hD0; 16'h0143: r = 8'hD1;
        16'h0147: r = 8'hD2; 16'h0150: r = 8'hD5; 16'h0158: r = 8'hD8;
        16'h016E: r = 8'hD9; 16'h0170: r = 8'hDB; 16'h0162: r = 8'hDE;
        16'h0155: r = 8'hE0; 16'h0103: r = 8'hE3; 16'h013A: r = 8'hE5;
        16'h0107: r = 8'hE6; 16'h010D: r = 8'hE8; 16'h0119: r = 8'hEA;
        16'h011B: r = 8'hEC; 16'h010F: r = 8'hEF; 16'h0111: r = 8'hF0;
        16'h0144: r = 8'hF1; 16'h0148: r = 8'hF2; 16'h0151: r = 8'hF5;
        16'h0159: r = 8'hF8; 16'h016F: r = 8'hF9; 16'h0171: r = 8'hFB;
        16'h0163: r = 8'hFE; 16'h02D9: r = 8'hFF;
        default: r = ByteQuestion;
      endcase
    end
    return r;
  endfunction

endpackage

// ----- src/utf8_to_cp1250_decoder.sv -----
// Top level of the UTF-8 to Windows-1250 decoder; joins front end, queue and
// back end. Depends on u2cp_pkg, u2cp_front, u2cp_queue and u2cp_back.
//
// The decoder takes one UTF-8 byte per transaction and gives Windows-1250 bytes,
// a line feed becoming CR LF and the last byte of a string adding a terminator.
// A byte is accepted in any cycle in which the internal queue of Depth work
// records has room, so bytes can follow back to back. A byte that yields results
// becomes one queue record; its first result is shown once the records ahead are
// popped. A record with n results holds the back end for n accepted pops, so
// output stalls or CR LF bursts fill the queue and then raise full.
module utf8_to_cp1250_decoder #(
  parameter int Depth = u2cp_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  u2cp_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output u2cp_pkg::out_item_t out_data
);
  import u2cp_pkg::*;
  work_t wr_data, rd_data;
  logic  wr_en, rd_en, q_full, q_empty;
  u2cp_front u_front (.clk, .rst, .push, .full, .in_data, .wr_en, .wr_data, .q_full);
  u2cp_queue #(.Depth(Depth)) u_queue (.clk, .rst, .wr_en, .wr_data, .q_full, .rd_en,
    .rd_data, .q_empty);
  u2cp_back u_back (.clk, .rst, .rd_data, .q_empty, .rd_en, .empty, .pop, .out_data);
endmodule

// ----- src/u2cp_front.sv -----
// Front end: accepts UTF-8 bytes, tracks open sequences and builds work records.
// Depends on u2cp_pkg.
module u2cp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  u2cp_pkg::in_item_t in_data,
  output logic               wr_en,
  output u2cp_pkg::work_t    wr_data,
  input  logic               q_full
);
  import u2cp_pkg::*;

  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [15:0] code_accum, code_accum_next;
  logic [7:0]  b;
  logic        accept;

  assign full = q_full;
  assign accept = push && !q_full;
  assign b = in_data.in_byte;

  always_comb begin
    bytes_pending_next = bytes_pending;
    code_accum_next = code_accum;
    wr_data = '0;
    if (bytes_pending != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        code_accum_next = {code_accum[9:0], b[5:0]};
        bytes_pending_next = bytes_pending - 2'd1;
        if (bytes_pending == 2'd1) begin
          wr_data.has_char = 1'b1;
          wr_data.char_map = 1'b1;
          wr_data.code = code_accum_next;
          code_accum_next = '0;
        end
      end else begin
        wr_data.has_char = 1'b1;
        wr_data.char_byte = ByteQuestion;
        bytes_pending_next = 2'd0;
        code_accum_next = '0;
      end
    end else if (b == ByteLf) begin
      wr_data.has_char = 1'b1;
      wr_data.char_is_lf = 1'b1;
    end else if (!b[7]) begin
      wr_data.has_char = 1'b1;
      wr_data.char_byte = b;
    end else if (b[7:6] == 2'b10) begin
    end else if (b[7:5] == 3'b110) begin
      code_accum_next = {11'd0, b[4:0]};
      bytes_pending_next = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      code_accum_next = {12'd0, b[3:0]};
      bytes_pending_next = 2'd2;
    end else begin
      wr_data.has_char = 1'b1;
      wr_data.char_byte = ByteQuestion;
    end
    if (in_data.string_last) begin
      wr_data.has_term = 1'b1;
      if (bytes_pending_next != 2'd0) begin
        wr_data.has_q = 1'b1;
        bytes_pending_next = 2'd0;
        code_accum_next = '0;
      end
    end
  end

  assign wr_en = accept && (wr_data.has_char || wr_data.has_term);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      code_accum <= '0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      code_accum <= code_accum_next;
    end
  end

endmodule

// ----- src/u2cp_queue.sv -----
// Short register queue between front and back end.
// Depends on u2cp_pkg.
module u2cp_queue #(
  parameter int Depth = u2cp_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  u2cp_pkg::work_t wr_data,
  output logic            q_full,
  input  logic            rd_en,
  output u2cp_pkg::work_t rd_data,
  output logic            q_empty
);
  import u2cp_pkg::*;

  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

  work_t         mem [Depth];
  logic [Aw-1:0] wptr, rptr;
  logic [Aw:0]   count;

  assign q_full = (count == (Aw+1)'(Depth));
  assign q_empty = (count == '0);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) wptr <= (wptr == Aw'(Depth - 1)) ? '0 : wptr + 1'b1;
      if (rd_en) rptr <= (rptr == Aw'(Depth - 1)) ? '0 : rptr + 1'b1;
      count <= count + (Aw+1)'(wr_en) - (Aw+1)'(rd_en);
    end
  end

endmodule

// ----- src/u2cp_back.sv -----
// Back end: maps code points and expands each work record into output items.
// Depends on u2cp_pkg.
module u2cp_back (
  input  logic                clk,
  input  logic                rst,
  input  u2cp_pkg::work_t     rd_data,
  input  logic                q_empty,
  output logic                rd_en,
  output logic                empty,
  input  logic                pop,
  output u2cp_pkg::out_item_t out_data
);
  import u2cp_pkg::*;

  localparam logic [1:0] PhChar = 2'd0;
  localparam logic [1:0] PhLf   = 2'd1;
  localparam logic [1:0] PhQ    = 2'd2;
  localparam logic [1:0] PhTerm = 2'd3;

  logic [1:0] phase, phase_next, first_ph;
  logic       more_lf, more_q, more_term, is_final, take;
  logic [7:0] ch;
  logic       started;
  logic [1:0] held;

  always_comb begin
    if (rd_data.has_char) first_ph = PhChar;
    else if (rd_data.has_q) first_ph = PhQ;
    else first_ph = PhTerm;
  end

  assign more_lf = rd_data.char_is_lf;
  assign more_q = rd_data.has_q;
  assign more_term = rd_data.has_term;

  assign phase = started ? held : first_ph;

  always_comb begin
    case (phase)
      PhChar: ch = rd_data.char_is_lf ? ByteCr :
                   (rd_data.char_map ? map_code(rd_data.code) : rd_data.char_byte);
      PhLf: ch = ByteLf;
      PhQ: ch = ByteQuestion;
      default: ch = 8'd0;
    endcase
  end

  always_comb begin
    case (phase)
      PhChar: is_final = !more_lf && !more_q && !more_term;
      PhLf: is_final = !more_q && !more_term;
      PhQ: is_final = !more_term;
      default: is_final = 1'b1;
    endcase
    case (phase)
      PhChar: phase_next = more_lf ? PhLf : (more_q ? PhQ : PhTerm);
      PhLf: phase_next = more_q ? PhQ : PhTerm;
      default: phase_next = PhTerm;
    endcase
  end

  assign empty = q_empty;
  assign take = pop && !q_empty;
  assign rd_en = take && is_final;

  assign out_data.out_byte = ch;
  assign out_data.byte_present = (phase != PhTerm);
  assign out_data.string_end = (phase == PhTerm);
  assign out_data.run_last = is_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      held <= PhChar;
    end else if (take) begin
      started <= !is_final;
      held <= phase_next;
    end
  end

endmodule

// ----- tb/utf8_to_cp1250_decoder_tb.sv -----
// Testbench for the UTF-8 to Windows-1250 decoder: a directed table, then random
// UTF-8 strings, all checked against an internal transcoder model.
// Depends on u2cp_pkg and utf8_to_cp1250_decoder.
module utf8_to_cp1250_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u2cp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  in_item_t in_data = '0;
  out_item_t out_data;

  utf8_to_cp1250_decoder u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       fixed;
    logic [7:0] want;
  } row_t;

  localparam logic [15:0] Cp1250Points [128] = '{
    16'h20AC, 16'h0000, 16'h201A, 16'h0000, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h0000, 16'h2030, 16'h0160, 16'h2039, 16'h015A, 16'h0164, 16'h017D, 16'h0179,
    16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h0000, 16'h2122, 16'h0161, 16'h203A, 16'h015B, 16'h0165, 16'h017E, 16'h017A,
    16'h00A0, 16'h02C7, 16'h02D8, 16'h0141, 16'h00A4, 16'h0104, 16'h00A6, 16'h00A7,
    16'h00A8, 16'h00A9, 16'h015E, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h017B,
    16'h00B0, 16'h00B1, 16'h02DB, 16'h0142, 16'h00B4, 16'h00B5, 16'h00B6, 16'h00B7,
    16'h00B8, 16'h0105, 16'h015F, 16'h00BB, 16'h013D, 16'h02DD, 16'h013E, 16'h017C,
    16'h0154, 16'h00C1, 16'h00C2, 16'h0102, 16'h00C4, 16'h0139, 16'h0106, 16'h00C7,
    16'h010C, 16'h00C9, 16'h0118, 16'h00CB, 16'h011A, 16'h00CD, 16'h00CE, 16'h010E,
    16'h0110, 16'h0143, 16'h0147, 16'h00D3, 16'h00D4, 16'h0150, 16'h00D6, 16'h00D7,
    16'h0158, 16'h016E, 16'h00DA, 16'h0170, 16'h00DC, 16'h00DD, 16'h0162, 16'h00DF,
    16'h0155, 16'h00E1, 16'h00E2, 16'h0103, 16'h00E4, 16'h013A, 16'h0107, 16'h00E7,
    16'h010D, 16'h00E9, 16'h0119, 16'h00EB, 16'h011B, 16'h00ED, 16'h00EE, 16'h010F,
    16'h0111, 16'h0144, 16'h0148, 16'h00F3, 16'h00F4, 16'h0151, 16'h00F6, 16'h00F7,
    16'h0159, 16'h016F, 16'h00FA, 16'h0171, 16'h00FC, 16'h00FD, 16'h0163, 16'h02D9
  };

  out_item_t expected_chars[$];
  out_item_t last_pred = '0;
  logic [1:0] seq_left = 2'd0;
  logic [15:0] code_point = 16'd0;
  int errors = 0;
  int pop_wait = 0;
  logic stim_done = 1'b0;

  function automatic logic [7:0] cp1250_of(input logic [15:0] u);
    if (u < 16'h00A0) return ByteQuestion;
    for (int i = 0; i < 128; i++) begin
      if (Cp1250Points[i] == u) return 8'h80 + i[7:0];
    end
    return ByteQuestion;
  endfunction

  task automatic transcode_byte(input in_item_t it);
    out_item_t res[$];
    out_item_t r;
    logic [7:0] b;
    b = it.in_byte;
    r = '0;
    r.byte_present = 1'b1;
    if (seq_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        code_point = {code_point[9:0], b[5:0]};
        seq_left = seq_left - 2'd1;
        if (seq_left == 2'd0) begin
          r.out_byte = cp1250_of(code_point);
          res.push_back(r);
          code_point = '0;
        end
      end else begin
        r.out_byte = ByteQuestion;
        res.push_back(r);
        seq_left = '0;
        code_point = '0;
      end
    end else if (b == ByteLf) begin
      r.out_byte = ByteCr;
      res.push_back(r);
      r.out_byte = ByteLf;
      res.push_back(r);
    end else if (b < 8'h80) begin
      r.out_byte = b;
      res.push_back(r);
    end else if (b[7:6] == 2'b10) begin
    end else if (b[7:5] == 3'b110) begin
      code_point = {11'd0, b[4:0]};
      seq_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      code_point = {12'd0, b[3:0]};
      seq_left = 2'd2;
    end else begin
      r.out_byte = ByteQuestion;
      res.push_back(r);
    end
    if (it.string_last) begin
      if (seq_left != 2'd0) begin
        r.out_byte = ByteQuestion;
        res.push_back(r);
        seq_left = '0;
        code_point = '0;
      end
      r = '0;
      r.string_end = 1'b1;
      res.push_back(r);
    end
    if (res.size() > 0) begin
      res[res.size()-1].run_last = 1'b1;
      last_pred = res[res.size()-1];
    end
    foreach (res[i]) expected_chars.push_back(res[i]);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    int g;
    it.in_byte = b;
    it.string_last = last;
    push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    transcode_byte(it);
    if ($urandom_range(0, 3) == 0) begin
      g = gap_len();
      if (g > 0) begin
        push <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic send_string(input int n);
    logic [7:0] b;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        send_byte($urandom_range(0, 4) == 0 ? ByteLf : 8'($urandom_range(1, 127)), i == n-1);
      end else if (k < 55) begin
        b = Cp1250Points[$urandom_range(0, 127)] < 16'h800 ? 8'hC0 : 8'hE0;
        if (b == 8'hC0) begin
          send_byte(8'hC0 | 8'($urandom_range(0, 31)), 1'b0);
          send_byte(8'h80 | 8'($urandom_range(0, 63)), i == n-1);
        end else begin
          send_byte(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
          send_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
          send_byte(8'h80 | 8'($urandom_range(0, 63)), i == n-1);
        end
      end else if (k < 85) begin
        logic [15:0] u;
        u = Cp1250Points[$urandom_range(0, 127)];
        if (u < 16'h0800) begin
          send_byte({3'b110, u[10:6]}, 1'b0);
          send_byte({2'b10, u[5:0]}, i == n-1);
        end else begin
          send_byte({4'b1110, u[15:12]}, 1'b0);
          send_byte({2'b10, u[11:6]}, 1'b0);
          send_byte({2'b10, u[5:0]}, i == n-1);
        end
      end else begin
        send_byte(8'($urandom_range(1, 255)), i == n-1);
      end
    end
  endtask

  row_t plan[$];

  initial begin
    row_t r;
    plan = '{
      '{8'h01, 1'b0, 1'b1, 8'h01}, '{8'h7F, 1'b0, 1'b1, 8'h7F},
      '{8'h0A, 1'b0, 1'b0, 8'h00}, '{8'h80, 1'b0, 1'b0, 8'h00},
      '{8'hBF, 1'b0, 1'b0, 8'h00}, '{8'hC3, 1'b0, 1'b0, 8'h00},
      '{8'hA1, 1'b0, 1'b1, 8'hE1}, '{8'hC1, 1'b0, 1'b0, 8'h00},
      '{8'hBF, 1'b0, 1'b1, ByteQuestion}, '{8'hE2, 1'b0, 1'b0, 8'h00},
      '{8'h82, 1'b0, 1'b0, 8'h00}, '{8'hAC, 1'b0, 1'b1, 8'h80},
      '{8'hE0, 1'b0, 1'b0, 8'h00}, '{8'h80, 1'b0, 1'b0, 8'h00},
      '{8'h80, 1'b0, 1'b1, ByteQuestion}, '{8'hEF, 1'b0, 1'b0, 8'h00},
      '{8'hBF, 1'b0, 1'b0, 8'h00}, '{8'hBF, 1'b0, 1'b1, ByteQuestion},
      '{8'hF0, 1'b0, 1'b1, ByteQuestion}, '{8'hFF, 1'b0, 1'b1, ByteQuestion},
      '{8'hC5, 1'b0, 1'b0, 8'h00}, '{8'h41, 1'b0, 1'b1, ByteQuestion},
      '{8'hE2, 1'b1, 1'b0, 8'h00}, '{8'h0A, 1'b1, 1'b0, 8'h00},
      '{8'h55, 1'b1, 1'b0, 8'h00}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i]) begin
      r = plan[i];
      send_byte(r.b, r.last);
      if (r.fixed && last_pred.out_byte != r.want) begin
        $error("out_byte table row %0d: expected %h, model %h", i, r.want,
               last_pred.out_byte);
        errors++;
      end
    end
    for (int n = 0; n < 50; n++) send_string($urandom_range(1, 4));
    push <= 1'b0;
    stim_done <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected transaction: out_byte %h", out_data.out_byte);
          errors++;
        end else begin
          out_item_t e;
          e = expected_chars.pop_front();
          if (out_data.out_byte !== e.out_byte) begin
            $error("out_byte: expected %h, actual %h", e.out_byte, out_data.out_byte);
            errors++;
          end
          if (out_data.byte_present !== e.byte_present) begin
            $error("byte_present: expected %b, actual %b", e.byte_present,
                   out_data.byte_present);
            errors++;
          end
          if (out_data.string_end !== e.string_end) begin
            $error("string_end: expected %b, actual %b", e.string_end, out_data.string_end);
            errors++;
          end
          if (out_data.run_last !== e.run_last) begin
            $error("run_last: expected %b, actual %b", e.run_last, out_data.run_last);
            errors++;
          end
        end
      end
      if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        pop_wait = gap_len();
        pop <= (pop_wait == 0);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    @(posedge stim_done);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
src/u2cp_pkg.sv
src/u2cp_front.sv
src/u2cp_queue.sv
src/u2cp_back.sv
src/utf8_to_cp1250_decoder.sv
tb/utf8_to_cp1250_decoder_tb.sv
